// ===== design/assert_macros.svh =====
// Assertion macros shared by the receive filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/prsf_pkg.sv =====
// Shared constants, types and codes of the packet receive sequence filter.
package prsf_pkg;

    localparam int HDR_LEN      = 18;
    localparam int MAX_PAYLOAD  = 1024;
    localparam int BUF_CAP      = HDR_LEN + MAX_PAYLOAD;
    localparam int IDX_W        = $clog2(BUF_CAP + 1);
    localparam int HDR_IDX_W    = $clog2(HDR_LEN);
    localparam int ACK_FRAME_LEN = 5;
    localparam int SIZE_LIMIT   = 16 + MAX_PAYLOAD;

    localparam logic [7:0]  ACK_CHAR  = 8'h2B;     // '+'
    localparam logic [16:0] SUM_PASS  = 17'h0FFFF;
    localparam logic [15:0] SIZE_SAT  = 16'hFFFF;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_CSUM_ERR  = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_SIZE_MISM = 3'd4;
    localparam logic [2:0] ST_ACK_FRAME = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_WINDOW = 2'd0;
    localparam logic [1:0] CFG_SERIAL_LIM  = 2'd1;
    localparam logic [1:0] CFG_PEER_FIRST  = 2'd2;
    localparam logic [1:0] CFG_RESTART     = 2'd3;

    localparam logic [29:0] RST_SYNC_WINDOW = 30'd16;
    localparam logic [30:0] RST_SERIAL_LIM  = 31'h4000_0000;
    localparam logic [31:0] RST_PEER_FIRST  = 32'h4000_0001;
    localparam logic [31:0] RST_RESTART     = 32'h4000_0002;
    localparam logic [31:0] RST_EXPECTED    = 32'h4000_0002;

    typedef struct packed {
        logic [29:0] sync_window;
        logic [30:0] serial_limit;
        logic [31:0] peer_first;
        logic [31:0] restart_marker;
    } t_serial_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic        send_ack;
        logic        exp_we;
        logic [31:0] exp_next;
    } t_verdict;

endpackage

// ===== design/packet_receive_sequence_filter.sv =====
// Top level: byte-serial frame receiver with checksum and serial filter.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------
//  in      | i_in_valid / o_in_ready                   | one frame byte request
//  out     | o_out_valid / i_out_ready                 | one verdict per frame
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data           | register write, no wait
//
//  One byte per cycle sustained; the per-byte sum add, header capture and
//  the last-byte verdict all sit between the input register and the result
//  register, so a verdict shows in the cycle after its last byte is taken.
//  Synchronous active-low reset clears the byte count, sum and valids, loads
//  the config registers with their defaults and the expected serial with
//  the restart value.
//  A held result stalls only a last byte waiting in the input register;
//  ordinary bytes keep flowing while the result waits.
module packet_receive_sequence_filter
    import prsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_send_ack,
    output logic [31:0] o_serial,
    output logic [15:0] o_payload_size,
    output logic [15:0] o_dest_app,
    output logic [15:0] o_src_app,
    output logic [15:0] o_dest_sub,
    output logic [15:0] o_src_sub,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

`include "assert_macros.svh"

    // ---- configuration registers ----
    t_serial_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_window    <= RST_SYNC_WINDOW;
            r_cfg.serial_limit   <= RST_SERIAL_LIM;
            r_cfg.peer_first     <= RST_PEER_FIRST;
            r_cfg.restart_marker <= RST_RESTART;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_WINDOW: r_cfg.sync_window    <= i_cfg_data[29:0];
                CFG_SERIAL_LIM:  r_cfg.serial_limit   <= i_cfg_data[30:0];
                CFG_PEER_FIRST:  r_cfg.peer_first     <= i_cfg_data;
                CFG_RESTART:     r_cfg.restart_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- input register ----
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       adv;        // input register moves into the frame state
    logic       r_out_valid;

    // a last byte needs a free result slot, other bytes always advance
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // ---- frame state ----
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [16:0]      r_sum;
    logic [16:0]      n_sum;
    logic [16:0]      sum_raw;
    logic [15:0]      addend;
    logic [31:0]      r_expected;
    logic [7:0]       r_hdr [HDR_LEN];
    logic [7:0]       n_hdr [HDR_LEN];
    logic [7:0]       hv    [HDR_LEN];   // header as seen by this frame
    logic             room;
    logic             in_hdr;
    logic             take;
    logic [31:0]      size_raw;

    assign room     = r_idx < IDX_W'(BUF_CAP);
    assign in_hdr   = r_idx < IDX_W'(HDR_LEN);
    assign n_idx    = room ? r_idx + IDX_W'(1) : r_idx;
    // size bytes are all present by the time payload bytes arrive
    assign size_raw = {r_hdr[5], r_hdr[4], r_hdr[3], r_hdr[2]};
    assign take     = room && (in_hdr || ((32'(r_idx) - 32'(HDR_LEN)) < size_raw));

    // little-endian pairs: odd positions are the high byte
    assign addend  = r_idx[0] ? {r_in_byte, 8'h00} : {8'h00, r_in_byte};
    assign sum_raw = r_sum + {1'b0, addend};
    always_comb begin
        n_sum = r_sum;
        if (take) begin
            n_sum = sum_raw[16] ? ({1'b0, sum_raw[15:0]} + 17'd1) : sum_raw;
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            n_hdr[i] = r_hdr[i];
        end
        if (in_hdr) begin
            n_hdr[r_idx[HDR_IDX_W-1:0]] = r_in_byte;
        end
        // bytes not yet received in this frame read as zero
        for (int i = 0; i < HDR_LEN; i++) begin
            hv[i] = (IDX_W'(i) < n_idx) ? n_hdr[i] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && in_hdr) begin
            r_hdr[r_idx[HDR_IDX_W-1:0]] <= r_in_byte;
        end
    end

    // ---- last-byte decision ----
    logic [31:0] hdr_size;
    logic [31:0] hdr_serial;
    logic        is_ack;
    t_verdict    verdict;

    assign hdr_size   = {hv[5], hv[4], hv[3], hv[2]};
    assign hdr_serial = {hv[17], hv[16], hv[15], hv[14]};
    assign is_ack     = (n_idx == IDX_W'(ACK_FRAME_LEN)) && (hv[4] == ACK_CHAR);

    prsf_verdict u_verdict (
        .i_csum_pass (n_sum == SUM_PASS),
        .i_serial    (hdr_serial),
        .i_size      (hdr_size),
        .i_rec_len   (n_idx),
        .i_expected  (r_expected),
        .i_cfg       (r_cfg),
        .o_verdict   (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_sum      <= '0;
            r_expected <= RST_EXPECTED;
        end else if (adv) begin
            if (r_in_last) begin
                r_idx <= '0;
                r_sum <= '0;
                if (!is_ack && verdict.exp_we) begin
                    r_expected <= verdict.exp_next;
                end
            end else begin
                r_idx <= n_idx;
                r_sum <= n_sum;
            end
        end
    end

    // ---- result register ----
    logic [2:0]  r_status;
    logic        r_send_ack;
    logic [31:0] r_serial;
    logic [15:0] r_size;
    logic [15:0] r_dest_app;
    logic [15:0] r_src_app;
    logic [15:0] r_dest_sub;
    logic [15:0] r_src_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            if (is_ack) begin
                r_status   <= ST_ACK_FRAME;
                r_send_ack <= 1'b0;
                r_serial   <= {hv[3], hv[2], hv[1], hv[0]};
                r_size     <= '0;
                r_dest_app <= '0;
                r_src_app  <= '0;
                r_dest_sub <= '0;
                r_src_sub  <= '0;
            end else begin
                r_status   <= verdict.status;
                r_send_ack <= verdict.send_ack;
                r_serial   <= hdr_serial;
                r_size     <= (hdr_size > {16'h0, SIZE_SAT}) ? SIZE_SAT : hdr_size[15:0];
                r_dest_app <= {hv[7],  hv[6]};
                r_src_app  <= {hv[9],  hv[8]};
                r_dest_sub <= {hv[11], hv[10]};
                r_src_sub  <= {hv[13], hv[12]};
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_send_ack     = r_send_ack;
    assign o_serial       = r_serial;
    assign o_payload_size = r_size;
    assign o_dest_app     = r_dest_app;
    assign o_src_app      = r_src_app;
    assign o_dest_sub     = r_dest_sub;
    assign o_src_sub      = r_src_sub;

    // ---- assertions ----
    `ASSERT_NXT(a_frame_restart, i_clk, i_rst_n, adv && r_in_last, r_idx == '0, "index not cleared after last byte")
    `ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, adv && r_in_last, o_out_valid, "last byte gave no result")
    `ASSERT_IMP(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= IDX_W'(BUF_CAP), "byte index past buffer")
    `ASSERT_IMP(a_sum_bound, i_clk, i_rst_n, 1'b1, r_sum <= 17'h10000, "running sum not folded")
    `ASSERT_IMP(a_ack_no_send, i_clk, i_rst_n, o_out_valid && (o_status == ST_ACK_FRAME), !o_send_ack, "ack frame asks for ack")

endmodule

// ===== design/prsf_verdict.sv =====
// Data frame verdict: checksum, serial resync rules, size checks.
module prsf_verdict
    import prsf_pkg::*;
(
    input  logic               i_csum_pass,
    input  logic [31:0]        i_serial,
    input  logic [31:0]        i_size,
    input  logic [IDX_W-1:0]   i_rec_len,
    input  logic [31:0]        i_expected,
    input  t_serial_cfg        i_cfg,
    output t_verdict           o_verdict
);

    logic [32:0] swin;
    logic        dup;
    logic [31:0] exp_sync;
    logic [31:0] exp_inc;
    logic        mismatch;

    assign swin = {1'b0, i_serial} + {3'b000, i_cfg.sync_window};
    assign mismatch = (i_rec_len < IDX_W'(HDR_LEN))
                   || (i_size != (32'(i_rec_len) - 32'(HDR_LEN)));

    always_comb begin
        dup      = 1'b0;
        exp_sync = i_serial;
        if (i_expected == i_serial) begin
            exp_sync = i_expected;
        end else if (i_serial == i_cfg.peer_first) begin
            exp_sync = 32'h0;
        end else if (i_expected == i_cfg.restart_marker) begin
            exp_sync = i_serial;
        end else if (((i_expected > i_serial) && ({1'b0, i_expected} <= swin))
                     || (swin >= {2'b00, i_cfg.serial_limit})) begin
            dup      = 1'b1;
            exp_sync = i_expected;
        end
    end

    // wraps to one at the limit
    always_comb begin
        exp_inc = exp_sync + 32'd1;
        if (exp_inc == {1'b0, i_cfg.serial_limit}) begin
            exp_inc = 32'd1;
        end
    end

    always_comb begin
        o_verdict.send_ack = i_csum_pass;
        o_verdict.exp_we   = i_csum_pass;
        o_verdict.exp_next = exp_sync;
        if (!i_csum_pass) begin
            o_verdict.status = ST_CSUM_ERR;
        end else if (dup) begin
            o_verdict.status = ST_DUPLICATE;
        end else if (i_size > 32'(SIZE_LIMIT)) begin
            o_verdict.status = ST_TOO_LARGE;
        end else if (mismatch) begin
            o_verdict.status = ST_SIZE_MISM;
        end else begin
            o_verdict.status   = ST_ACCEPTED;
            o_verdict.exp_next = exp_inc;
        end
    end

endmodule
